FILE: design/sltc_pkg.sv
// Shared types, constants and codes for the sorted load table.
// No dependencies.
package sltc_pkg;
	localparam int Capacity = 64;
	localparam int SlotW = 6;
	localparam int CntW = 7;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_WRITE  = 2'd2,
		REQ_READ   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_ROW      = 3'd2,
		ST_COL      = 3'd3,
		ST_OCCUPIED = 3'd4,
		ST_SLOT     = 3'd5,
		ST_ZERO_V   = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		FLD_P    = 2'd0,
		FLD_Q    = 2'd1,
		FLD_I_RE = 2'd2,
		FLD_I_IM = 2'd3
	} field_t;

	localparam logic [0:0] CFG_ROW_LIMIT = 1'b0;
	localparam logic [0:0] CFG_COL_LIMIT = 1'b1;

	typedef struct packed {
		logic [1:0]   req_type;
		logic [7:0]   row;
		logic [7:0]   col;
		logic         overwrite;
		logic signed [15:0] p_demand;
		logic signed [15:0] q_demand;
		logic signed [15:0] volt_re;
		logic signed [15:0] volt_im;
		logic [5:0]   slot;
		logic [1:0]   field_sel;
		logic signed [15:0] wr_value;
	} in_item_t;

	typedef struct packed {
		logic [2:0]   status;
		logic         found;
		logic [6:0]   entry_count;
		logic         rd_valid;
		logic [7:0]   rd_row;
		logic [7:0]   rd_col;
		logic signed [15:0] rd_p;
		logic signed [15:0] rd_q;
		logic signed [15:0] rd_i_re;
		logic signed [15:0] rd_i_im;
	} out_item_t;

	typedef struct packed {
		logic valid;
		logic [7:0] row;
		logic [7:0] col;
		logic [15:0] p;
		logic [15:0] q;
		logic [15:0] i_re;
		logic [15:0] i_im;
	} entry_t;

	typedef struct packed {
		logic start;
		logic neg;
		logic [47:0] mag;
		logic [32:0] den;
	} div_req_t;
endpackage

FILE: design/sltc_div.sv
// Restoring divider: round(4096*num/den), ties away, saturated to 16 bits.
// Depends on sltc_pkg.
module sltc_div (
	input  logic clk,
	input  logic arst_n,
	input  sltc_pkg::div_req_t req,
	output logic done,
	output logic [15:0] quo
);
	import sltc_pkg::*;

	// dividend = 2*(mag<<12)+den up to 62 bits, divisor = 2*den (34 bits)
	logic [63:0] rem_q;
	logic [63:0] dvd_q;
	logic [33:0] dvs_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        neg_q;
	logic [64:0] trial;
	logic [63:0] rem_sh;
	logic [63:0] q_full;

	assign rem_sh = {rem_q[62:0], dvd_q[63]};
	assign trial = {1'b0, rem_sh} - {31'd0, dvs_q};
	assign q_full = dvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= {3'd0, req.mag, 13'd0} + {31'd0, req.den};
			dvs_q <= {req.den, 1'b0};
			neg_q <= req.neg;
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				dvd_q <= {dvd_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				dvd_q <= {dvd_q[62:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (neg_q) begin
			if (q_full >= 64'd32768) quo = 16'h8000;
			else quo = 16'd0 - q_full[15:0];
		end else begin
			if (q_full > 64'd32767) quo = 16'h7FFF;
			else quo = q_full[15:0];
		end
	end
endmodule

FILE: design/sorted_load_table_with_current_core.sv
// Top level of the sorted load table: sequencer, entry store, shared units.
// Depends on sltc_pkg and sltc_div.
//
// Usage: pulse start with an item while busy is low; the item is taken at
// that edge and busy rises. For inserts and removes the sequencer then
// scans the table one slot at a time; an insert shares one 17x17 multiplier
// over six products and runs the 64-step divider once for each current
// component, and entries move one slot a cycle when inserting or removing.
// One result appears on result for exactly one cycle with result_valid
// high; it cannot be held off. Reads and writes go from the scan state to
// the read state and then the done state; for inserts and removes the wait
// is set by the scan, the shift and the two divider runs. busy falls with
// the result, so the next item is taken at the edge that ends the result
// cycle at the earliest. Configuration writes on cfg_valid/cfg_ready are
// taken whenever busy is low. Reset empties the table, sets both limits to
// 256 and leaves the block idle.
module sorted_load_table_with_current_core (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  sltc_pkg::in_item_t item,
	output logic result_valid,
	output sltc_pkg::out_item_t result,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [0:0] cfg_index,
	input  logic [8:0] cfg_data
);
	import sltc_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_SCAN  = 10'b0000000010,
		S_MUL   = 10'b0000000100,
		S_DIVR  = 10'b0000001000,
		S_DIVI  = 10'b0000010000,
		S_SHUP  = 10'b0000100000,
		S_SHDN  = 10'b0001000000,
		S_STORE = 10'b0010000000,
		S_RD    = 10'b0100000000,
		S_DONE  = 10'b1000000000
	} state_t;

	state_t state_q;
	in_item_t it_q;
	logic [8:0] row_lim_q, col_lim_q;
	logic [Capacity-1:0] vld_q;
	entry_t mem [Capacity];
	entry_t rd_q;
	logic [SlotW-1:0] raddr;
	logic [CntW-1:0] cnt_q, k_q, m_q;
	logic taken_q, rd_ok_q;
	logic [2:0] mstep_q;
	logic signed [33:0] acc_re_q, acc_im_q, den_q;
	logic signed [16:0] ma, mb;
	logic signed [33:0] prod_q;
	logic [2:0] pstep_q;
	logic [15:0] ire_q;
	div_req_t dreq;
	logic ddone;
	logic [15:0] dquo;
	logic [15:0] key, old_key;
	out_item_t res_q;
	logic wr_en;
	logic [SlotW-1:0] waddr;
	entry_t wdata;
	entry_t rd_eff;

	sltc_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .done(ddone), .quo(dquo));

	assign busy = (state_q != S_IDLE);
	assign cfg_ready = !busy;
	assign key = {it_q.row, it_q.col};
	assign rd_eff = rd_q;
	assign old_key = {rd_eff.row, rd_eff.col};

	always_ff @(posedge clk) begin
		if (wr_en) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
		rd_ok_q <= vld_q[raddr];
	end

	always_comb begin
		raddr = k_q[SlotW-1:0];
		case (state_q)
			S_IDLE: raddr = '0;
			S_SHUP: raddr = m_q[SlotW-1:0] - SlotW'(1);
			S_SHDN: raddr = m_q[SlotW-1:0] + SlotW'(1);
			S_RD:   raddr = it_q.slot;
			default: raddr = k_q[SlotW-1:0];
		endcase
	end

	// multiplier operand sequencing: P*Ur, Q*Ui, P*Ui, Q*Ur, Ur*Ur, Ui*Ui
	always_comb begin
		ma = 17'sd0;
		mb = 17'sd0;
		case (pstep_q)
			3'd0: begin ma = 17'(it_q.p_demand); mb = 17'(it_q.volt_re); end
			3'd1: begin ma = 17'(it_q.q_demand); mb = 17'(it_q.volt_im); end
			3'd2: begin ma = 17'(it_q.p_demand); mb = 17'(it_q.volt_im); end
			3'd3: begin ma = 17'(it_q.q_demand); mb = 17'(it_q.volt_re); end
			3'd4: begin ma = 17'(it_q.volt_re); mb = 17'(it_q.volt_re); end
			3'd5: begin ma = 17'(it_q.volt_im); mb = 17'(it_q.volt_im); end
			default: begin ma = 17'sd0; mb = 17'sd0; end
		endcase
	end

	always_comb begin
		dreq = '0;
		if (state_q == S_MUL && mstep_q == 3'd7) begin
			dreq.start = 1'b1;
			dreq.neg = acc_re_q[33];
			dreq.mag = 48'(acc_re_q[33] ? -acc_re_q : acc_re_q);
			dreq.den = den_q[32:0];
		end else if (state_q == S_DIVR && ddone) begin
			dreq.start = 1'b1;
			dreq.neg = acc_im_q[33];
			dreq.mag = 48'(acc_im_q[33] ? -acc_im_q : acc_im_q);
			dreq.den = den_q[32:0];
		end
	end

	always_comb begin
		wr_en = 1'b0;
		waddr = it_q.slot;
		wdata = rd_q;
		case (state_q)
			S_SHUP: begin
				wr_en = (m_q < cnt_q);
				waddr = m_q[SlotW-1:0] + SlotW'(1);
				wdata = rd_q;
			end
			S_SHDN: begin
				wr_en = (m_q > k_q);
				waddr = m_q[SlotW-1:0] - SlotW'(1);
				wdata = (m_q < cnt_q) ? rd_q : '0;
			end
			S_STORE: begin
				wr_en = 1'b1;
				waddr = k_q[SlotW-1:0];
				wdata = {1'b1, it_q.row, it_q.col, it_q.p_demand, it_q.q_demand,
					ire_q, dquo};
			end
			S_RD: begin
				// field write: read-modify-write of the slot
				wr_en = (it_q.req_type == REQ_WRITE) && (mstep_q == 3'd1);
				waddr = it_q.slot;
				wdata = rd_ok_q ? rd_q : '0;
				case (it_q.field_sel)
					FLD_P:    wdata.p = it_q.wr_value;
					FLD_Q:    wdata.q = it_q.wr_value;
					FLD_I_RE: wdata.i_re = it_q.wr_value;
					FLD_I_IM: wdata.i_im = it_q.wr_value;
					default:  wdata.p = it_q.wr_value;
				endcase
				wdata.valid = rd_ok_q & rd_q.valid;
			end
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			row_lim_q <= 9'd256;
			col_lim_q <= 9'd256;
			vld_q <= '0;
			cnt_q <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_ROW_LIMIT) row_lim_q <= cfg_data;
				else col_lim_q <= cfg_data;
			end
			if (wr_en) vld_q[waddr] <= 1'b1;
			case (state_q)
				S_IDLE: if (start) state_q <= S_SCAN;
				S_SCAN: begin
					if (it_q.req_type == REQ_WRITE || it_q.req_type == REQ_READ) begin
						if ({26'd0, it_q.slot} >= Capacity) state_q <= S_DONE;
						else state_q <= S_RD;
					end else if (it_q.req_type == REQ_INSERT && (cnt_q >= CntW'(Capacity)
						|| {1'b0, it_q.row} >= row_lim_q || {1'b0, it_q.col} >= col_lim_q)) begin
						state_q <= S_DONE;
					end else if (mstep_q != 3'd0) begin
						if (k_q >= cnt_q || (rd_ok_q && old_key >= key)) begin
							if (it_q.req_type == REQ_REMOVE) begin
								state_q <= (k_q < cnt_q && old_key == key) ? S_SHDN : S_DONE;
							end else if (k_q < cnt_q && old_key == key && !it_q.overwrite) begin
								state_q <= S_DONE;
							end else if (it_q.volt_re == 16'sd0 && it_q.volt_im == 16'sd0) begin
								state_q <= S_DONE;
							end else begin
								state_q <= S_MUL;
							end
						end
					end
				end
				S_MUL: if (mstep_q == 3'd7) state_q <= S_DIVR;
				S_DIVR: if (ddone) state_q <= S_DIVI;
				S_DIVI: if (ddone) state_q <= taken_q ? S_STORE : S_SHUP;
				S_SHUP: if (m_q <= k_q) begin
					state_q <= S_STORE;
					cnt_q <= cnt_q + CntW'(1);
				end
				S_STORE: state_q <= S_DONE;
				S_SHDN: if (m_q >= cnt_q) begin
					state_q <= S_DONE;
					cnt_q <= cnt_q - CntW'(1);
				end
				S_RD: if (mstep_q == 3'd1) state_q <= S_DONE;
				S_DONE: begin
					state_q <= S_IDLE;
					result_valid <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				it_q <= item;
				k_q <= '0;
				mstep_q <= '0;
				taken_q <= 1'b0;
				res_q <= '0;
			end
			S_SCAN: begin
				mstep_q <= 3'd1;
				pstep_q <= '0;
				acc_re_q <= '0;
				acc_im_q <= '0;
				den_q <= '0;
				if (it_q.req_type == REQ_WRITE || it_q.req_type == REQ_READ) begin
					mstep_q <= '0;
					if ({26'd0, it_q.slot} >= Capacity) res_q.status <= ST_SLOT;
				end else if (it_q.req_type == REQ_INSERT && cnt_q >= CntW'(Capacity))
					res_q.status <= ST_FULL;
				else if (it_q.req_type == REQ_INSERT && {1'b0, it_q.row} >= row_lim_q)
					res_q.status <= ST_ROW;
				else if (it_q.req_type == REQ_INSERT && {1'b0, it_q.col} >= col_lim_q)
					res_q.status <= ST_COL;
				else if (mstep_q != 3'd0) begin
					if (k_q >= cnt_q || (rd_ok_q && old_key >= key)) begin
						mstep_q <= '0;
						taken_q <= (k_q < cnt_q && old_key == key);
						m_q <= (it_q.req_type == REQ_REMOVE) ? k_q : cnt_q;
						if (it_q.req_type == REQ_REMOVE) res_q.found <= (k_q < cnt_q && old_key == key);
						else if (k_q < cnt_q && old_key == key && !it_q.overwrite)
							res_q.status <= ST_OCCUPIED;
						else if (it_q.volt_re == 16'sd0 && it_q.volt_im == 16'sd0)
							res_q.status <= ST_ZERO_V;
						else res_q.found <= (k_q < cnt_q && old_key == key);
					end else begin
						k_q <= k_q + CntW'(1);
						mstep_q <= '0;
					end
				end
			end
			S_MUL: begin
				mstep_q <= mstep_q + 3'd1;
				if (mstep_q <= 3'd5) begin
					prod_q <= 34'(ma * mb);
					pstep_q <= pstep_q + 3'd1;
				end
				case (mstep_q)
					3'd1: acc_re_q <= acc_re_q + prod_q;
					3'd2: acc_re_q <= acc_re_q + prod_q;
					3'd3: acc_im_q <= acc_im_q + prod_q;
					3'd4: acc_im_q <= acc_im_q - prod_q;
					3'd5: den_q <= den_q + prod_q;
					3'd6: den_q <= den_q + prod_q;
					default: ;
				endcase
			end
			S_DIVR: if (ddone) ire_q <= dquo;
			S_SHUP: m_q <= m_q - CntW'(1);
			S_SHDN: m_q <= m_q + CntW'(1);
			S_RD: begin
				mstep_q <= mstep_q + 3'd1;
				if (mstep_q == 3'd1 && it_q.req_type == REQ_READ) begin
					res_q.rd_valid <= rd_ok_q & rd_q.valid;
					res_q.rd_row <= rd_ok_q ? rd_q.row : '0;
					res_q.rd_col <= rd_ok_q ? rd_q.col : '0;
					res_q.rd_p <= rd_ok_q ? rd_q.p : '0;
					res_q.rd_q <= rd_ok_q ? rd_q.q : '0;
					res_q.rd_i_re <= rd_ok_q ? rd_q.i_re : '0;
					res_q.rd_i_im <= rd_ok_q ? rd_q.i_im : '0;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		result = res_q;
		result.entry_count = cnt_q;
	end
endmodule

FILE: verif/testbench.sv
// Self-checking testbench for sorted_load_table_with_current_core.
// Drives insert, remove, write and read items, predicts each result in a
// behavioural copy of the table; depends on sltc_pkg and the core RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import sltc_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_item_t item = '0;
	logic result_valid;
	out_item_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [0:0] cfg_index = '0;
	logic [8:0] cfg_data = '0;

	sorted_load_table_with_current_core uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	entry_t tbl [Capacity];
	int unsigned n_loads;
	int unsigned rows_ok, cols_ok;
	out_item_t awaited [$];
	int unsigned n_bad;

	typedef struct {
		in_item_t stim;
		bit known;
		out_item_t res;
	} row_t;

	function automatic logic [15:0] q12_quot(longint num, longint den);
		bit neg;
		longint unsigned mag, q;
		neg = num < 0;
		mag = neg ? -num : num;
		q = (2 * (mag << 12) + den) / (2 * den);
		if (neg) return (q >= 32768) ? 16'h8000 : 16'(65536 - q);
		return (q > 32767) ? 16'h7fff : 16'(q);
	endfunction

	function automatic out_item_t table_step(in_item_t it);
		out_item_t o;
		int k, m;
		bit taken;
		longint p, q, ur, ui, den;
		o = '0;
		k = 0;
		taken = 0;
		case (req_t'(it.req_type))
			REQ_INSERT: begin
				if (n_loads >= Capacity) o.status = ST_FULL;
				else if (it.row >= rows_ok) o.status = ST_ROW;
				else if (it.col >= cols_ok) o.status = ST_COL;
				else begin
					for (k = 0; k < n_loads; k++) begin
						if ({tbl[k].row, tbl[k].col} == {it.row, it.col}) begin
							taken = 1;
							break;
						end
						if ({it.row, it.col} < {tbl[k].row, tbl[k].col}) break;
					end
					p = it.p_demand; q = it.q_demand;
					ur = it.volt_re; ui = it.volt_im;
					den = ur * ur + ui * ui;
					if (taken && !it.overwrite) o.status = ST_OCCUPIED;
					else if (den == 0) o.status = ST_ZERO_V;
					else begin
						if (!taken) begin
							for (m = n_loads; m > k; m--) tbl[m] = tbl[m - 1];
							n_loads++;
						end else o.found = 1'b1;
						tbl[k].valid = 1'b1;
						tbl[k].row = it.row;
						tbl[k].col = it.col;
						tbl[k].p = it.p_demand;
						tbl[k].q = it.q_demand;
						tbl[k].i_re = q12_quot(p * ur + q * ui, den);
						tbl[k].i_im = q12_quot(p * ui - q * ur, den);
					end
				end
			end
			REQ_REMOVE: begin
				for (k = 0; k < n_loads; k++)
					if (tbl[k].row == it.row && tbl[k].col == it.col) break;
				if (k < n_loads) begin
					o.found = 1'b1;
					for (m = k; m + 1 < n_loads; m++) tbl[m] = tbl[m + 1];
					n_loads--;
					tbl[n_loads] = '0;
				end
			end
			REQ_WRITE: begin
				if (it.slot >= Capacity) o.status = ST_SLOT;
				else case (field_t'(it.field_sel))
					FLD_P: tbl[it.slot].p = it.wr_value;
					FLD_Q: tbl[it.slot].q = it.wr_value;
					FLD_I_RE: tbl[it.slot].i_re = it.wr_value;
					default: tbl[it.slot].i_im = it.wr_value;
				endcase
			end
			default: begin
				if (it.slot >= Capacity) o.status = ST_SLOT;
				else begin
					o.rd_valid = tbl[it.slot].valid;
					o.rd_row = tbl[it.slot].row;
					o.rd_col = tbl[it.slot].col;
					o.rd_p = tbl[it.slot].p;
					o.rd_q = tbl[it.slot].q;
					o.rd_i_re = tbl[it.slot].i_re;
					o.rd_i_im = tbl[it.slot].i_im;
				end
			end
		endcase
		o.entry_count = 7'(n_loads);
		return o;
	endfunction

	always @(posedge clk) begin
		out_item_t want;
		if (result_valid) begin
			if (awaited.size() == 0) begin
				n_bad++;
				if (n_bad <= 10) $display("unexpected result %h", result);
			end else begin
				want = awaited.pop_front();
				if (result !== want) begin
					n_bad++;
					if (n_bad <= 10)
						$display("mismatch: expected %h, got %h", want, result);
				end
			end
		end
	end

	// start stays high after an item is taken; drop it before any pause
	task automatic idle_gap();
		int unsigned g;
		g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if (g != 0) start <= 1'b0;
		repeat (g) @(posedge clk);
	endtask

	task automatic issue(in_item_t it, bit known, out_item_t res, bit gaps);
		out_item_t pred;
		if (gaps) idle_gap();
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		pred = table_step(it);
		if (known && pred !== res) begin
			n_bad++;
			if (n_bad <= 10) $display("table row: typed %h, predicted %h", res, pred);
		end
		awaited.push_back(pred);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (awaited.size() != 0) @(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	task automatic set_limit(logic [0:0] idx, logic [8:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		if (idx == CFG_ROW_LIMIT) rows_ok = v;
		else cols_ok = v;
	endtask

	function automatic in_item_t rand_item(int unsigned span);
		in_item_t it;
		logic [127:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom};
		it = raw[$bits(in_item_t)-1:0];
		it.req_type = ($urandom_range(0, 9) < 5) ? REQ_INSERT : 2'($urandom_range(1, 3));
		if ($urandom_range(0, 3) != 0) begin
			it.row = 8'($urandom_range(0, span));
			it.col = 8'($urandom_range(0, span));
		end
		if ($urandom_range(0, 49) == 0) begin
			it.volt_re = '0;
			it.volt_im = '0;
		end
		return it;
	endfunction

	function automatic in_item_t mk(req_t r, logic [7:0] rw, logic [7:0] cl, logic ow,
			logic [15:0] vr, logic [5:0] sl, field_t f, logic [15:0] wv);
		in_item_t it;
		it = '0;
		it.req_type = r; it.row = rw; it.col = cl; it.overwrite = ow;
		it.p_demand = 16'h1000; it.q_demand = 16'h0800;
		it.volt_re = vr; it.volt_im = 16'h0000;
		it.slot = sl; it.field_sel = f; it.wr_value = wv;
		return it;
	endfunction

	function automatic out_item_t st(status_t s, logic fnd, int cnt);
		out_item_t o;
		o = '0;
		o.status = s; o.found = fnd; o.entry_count = 7'(cnt);
		return o;
	endfunction

	initial begin
		row_t plan [$];
		in_item_t it;
		int unsigned span;
		for (int i = 0; i < Capacity; i++) tbl[i] = '0;
		n_loads = 0; rows_ok = 256; cols_ok = 256; n_bad = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		plan.push_back('{mk(REQ_READ, 0, 0, 0, 16'h1000, 0, FLD_P, 0), 1, st(ST_OK, 0, 0)});
		plan.push_back('{mk(REQ_REMOVE, 3, 3, 0, 16'h1000, 0, FLD_P, 0), 1, st(ST_OK, 0, 0)});
		plan.push_back('{mk(REQ_INSERT, 5, 5, 0, 16'h0000, 0, FLD_P, 0), 1, st(ST_ZERO_V, 0, 0)});
		plan.push_back('{mk(REQ_INSERT, 255, 255, 0, 16'h1000, 0, FLD_P, 0), 1, st(ST_OK, 0, 1)});
		plan.push_back('{mk(REQ_INSERT, 0, 0, 0, 16'h1000, 0, FLD_P, 0), 1, st(ST_OK, 0, 2)});
		plan.push_back('{mk(REQ_INSERT, 0, 255, 0, 16'h0001, 0, FLD_P, 0), 1, st(ST_OK, 0, 3)});
		plan.push_back('{mk(REQ_INSERT, 0, 0, 0, 16'h1000, 0, FLD_P, 0), 1, st(ST_OCCUPIED, 0, 3)});
		plan.push_back('{mk(REQ_INSERT, 0, 0, 1, 16'h8000, 0, FLD_P, 0), 1, st(ST_OK, 1, 3)});
		plan.push_back('{mk(REQ_WRITE, 0, 0, 0, 16'h1000, 63, FLD_I_IM, 16'h8000), 1, st(ST_OK, 0, 3)});
		plan.push_back('{mk(REQ_WRITE, 0, 0, 0, 16'h1000, 1, FLD_P, 16'h7fff), 1, st(ST_OK, 0, 3)});
		plan.push_back('{mk(REQ_WRITE, 0, 0, 0, 16'h1000, 1, FLD_Q, 16'hffff), 0, '0});
		plan.push_back('{mk(REQ_WRITE, 0, 0, 0, 16'h1000, 2, FLD_I_RE, 16'h1234), 0, '0});
		plan.push_back('{mk(REQ_READ, 0, 0, 0, 16'h1000, 63, FLD_P, 0), 0, '0});
		plan.push_back('{mk(REQ_READ, 0, 0, 0, 16'h1000, 0, FLD_P, 0), 0, '0});
		plan.push_back('{mk(REQ_READ, 0, 0, 0, 16'h1000, 1, FLD_P, 0), 0, '0});
		plan.push_back('{mk(REQ_READ, 0, 0, 0, 16'h1000, 2, FLD_P, 0), 0, '0});
		plan.push_back('{mk(REQ_REMOVE, 0, 0, 0, 16'h1000, 0, FLD_P, 0), 1, st(ST_OK, 1, 2)});
		plan.push_back('{mk(REQ_READ, 0, 0, 0, 16'h1000, 2, FLD_P, 0), 0, '0});
		foreach (plan[i]) issue(plan[i].stim, plan[i].known, plan[i].res, 0);
		drain();

		set_limit(CFG_ROW_LIMIT, 9'd1);
		set_limit(CFG_COL_LIMIT, 9'd1);
		issue(mk(REQ_INSERT, 1, 0, 0, 16'h1000, 0, FLD_P, 0), 1, st(ST_ROW, 0, 2), 0);
		issue(mk(REQ_INSERT, 0, 1, 0, 16'h1000, 0, FLD_P, 0), 1, st(ST_COL, 0, 2), 0);
		issue(mk(REQ_INSERT, 0, 0, 0, 16'h1000, 0, FLD_P, 0), 1, st(ST_OK, 0, 3), 0);
		drain();

		// phases: wide keys, narrow limits and a dense insert pass to fill the table
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin set_limit(CFG_ROW_LIMIT, 9'd256); set_limit(CFG_COL_LIMIT, 9'd256); span = 255; end
				1: begin set_limit(CFG_ROW_LIMIT, 9'd5); set_limit(CFG_COL_LIMIT, 9'd7); span = 9; end
				2: begin set_limit(CFG_ROW_LIMIT, 9'd256); set_limit(CFG_COL_LIMIT, 9'd256); span = 15; end
				3: begin set_limit(CFG_ROW_LIMIT, 9'd200); set_limit(CFG_COL_LIMIT, 9'd3); span = 255; end
				4: begin set_limit(CFG_ROW_LIMIT, 9'd256); set_limit(CFG_COL_LIMIT, 9'd256); span = 11; end
				default: begin set_limit(CFG_ROW_LIMIT, 9'd16); set_limit(CFG_COL_LIMIT, 9'd256); span = 31; end
			endcase
			for (int n = 0; n < 215; n++) begin
				it = rand_item(span);
				if (ph == 4 && $urandom_range(0, 3) != 0) it.req_type = REQ_INSERT;
				issue(it, 0, '0, 1);
				if (n == 100 && ph == 2) drain();
			end
			drain();
		end

		if (n_bad == 0) $display("PASSED: all results match");
		else $display("FAILED: results differ");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
